/* hw/rtl/dde_pkg.sv */
// ----------------------------------------------------------------------------
// dde_pkg
// shared command and status types for the decimal digit emitter
// ----------------------------------------------------------------------------
`default_nettype none

package dde_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture input word, clear bcd and bit counter, load digit count
    logic dabble;    // one shift-and-add-3 step
    logic shift;     // drop the top bcd digit, count one digit down
    logic sel_sign;  // present the minus sign on the output
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic conv_done;  // current dabble step is the last one
    logic top_zero;   // top bcd digit is zero
    logic cnt_one;    // one digit left
    logic neg;        // captured value was negative
  } stat_t;

  localparam int unsigned DigitBits = 4;

endpackage

`default_nettype wire

/* hw/rtl/dde_ctrl.sv */
// ----------------------------------------------------------------------------
// dde_ctrl
// sequencer: accept, convert, skip leading zeros, emit sign and digits
// ----------------------------------------------------------------------------
`default_nettype none

module dde_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  input  wire dde_pkg::stat_t stat,
  output dde_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble = 1'b1;
        if (stat.conv_done) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.cnt_one) begin
          cmd.shift = 1'b1;
        end else if (stat.neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SIGN: begin
        m_tvalid     = 1'b1;
        cmd.sel_sign = 1'b1;
        if (m_tready) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (stat.cnt_one) begin
            state_next = ST_IDLE;
          end else begin
            cmd.shift = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/dde_datapath.sv */
// ----------------------------------------------------------------------------
// dde_datapath
// sign handling, shift-and-add-3 bcd converter and digit output register
// ----------------------------------------------------------------------------
`default_nettype none

module dde_datapath #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned NDIG      = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic [31:0]   s_tdata,
  input  wire dde_pkg::cmd_t cmd,
  output dde_pkg::stat_t     stat,
  output logic [7:0]         m_tdata,
  output logic               m_tuser,
  output logic               m_tlast
);

  localparam int unsigned BcdBits = NDIG * dde_pkg::DigitBits;
  localparam int unsigned BcW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned CntW    = $clog2(NDIG + 1);

  logic                 signed_mode;
  logic [WORD_BITS-1:0] bin;
  logic [BcdBits-1:0]   bcd;
  logic [BcW-1:0]       bitcnt;
  logic [CntW-1:0]      cnt;
  logic                 neg;

  logic [63:0]          wide_in;
  logic [WORD_BITS-1:0] v_in;
  logic                 v_neg;
  logic [WORD_BITS-1:0] mag;
  logic [BcdBits-1:0]   bcd_adj;
  logic [3:0]           top_digit;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b1;
    end else if (cfg_we) begin
      signed_mode <= cfg_wdata;
    end
  end

  always_comb begin
    wide_in = {32'd0, s_tdata};
    v_in    = wide_in[WORD_BITS-1:0];
    v_neg   = signed_mode & v_in[WORD_BITS-1];
    // most negative value wraps to 2^(WORD_BITS-1), read as unsigned
    mag     = v_neg ? (~v_in + WORD_BITS'(1)) : v_in;
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < int'(NDIG); i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin    <= mag;
      neg    <= v_neg;
      bcd    <= '0;
      bitcnt <= '0;
      cnt    <= CntW'(NDIG);
    end else if (cmd.dabble) begin
      bcd    <= {bcd_adj[BcdBits-2:0], bin[WORD_BITS-1]};
      bin    <= {bin[WORD_BITS-2:0], 1'b0};
      bitcnt <= bitcnt + BcW'(1);
    end else if (cmd.shift) begin
      bcd    <= {bcd[BcdBits-5:0], 4'd0};
      cnt    <= cnt - CntW'(1);
    end
  end

  assign top_digit = bcd[BcdBits-1 -: 4];

  always_comb begin
    stat.conv_done = (bitcnt == BcW'(WORD_BITS - 1));
    stat.top_zero  = (top_digit == 4'd0);
    stat.cnt_one   = (cnt == CntW'(1));
    stat.neg       = neg;
  end

  assign m_tuser = cmd.sel_sign;
  assign m_tdata = cmd.sel_sign ? 8'd0 : {4'd0, top_digit};
  assign m_tlast = !cmd.sel_sign && stat.cnt_one;

endmodule

`default_nettype wire

/* hw/rtl/decimal_digit_emitter.sv */
// ----------------------------------------------------------------------------
// decimal_digit_emitter
// converts one binary word to decimal digits, most significant first
// ----------------------------------------------------------------------------
// Each input transfer carries one word; its low WORD_BITS bits are converted
// and sent out as one transfer per symbol: an optional minus sign (tuser=1,
// only when signed_mode is set and the word is negative), then the decimal
// digits with no leading zeros, tlast on the final digit. Zero gives a single
// 0 digit and the most negative value converts to 2^(WORD_BITS-1). One word is
// handled at a time: the input is ready only when the previous run is fully
// sent. A word is accepted, run through the bit-serial shift-and-add-3 loop
// with one step per input bit, stripped of its leading zero digits one at a
// time, then sent as one result transfer per symbol as the output takes them.
// signed_mode resets to 1 and must only be written while no run is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_digit_emitter #(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,  // signed_mode
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // [31:0] value_word
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [3:0] digit_value, [7:4] zero
  output logic             m_tuser,    // symbol_kind: 1 minus sign
  output logic             m_tlast     // last_of_run
);

  // decimal digits needed for 2^WORD_BITS - 1
  localparam int unsigned NDIG = (WORD_BITS * 30103) / 100000 + 1;

  dde_pkg::cmd_t  cmd;
  dde_pkg::stat_t stat;

  // sequencer
  dde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // converter and output payload
  dde_datapath #(
    .WORD_BITS (WORD_BITS),
    .NDIG      (NDIG)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // one run at a time: no input taken while results are pending
  a_one_run: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while output valid");

  // after an input transfer the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after transfer");

  // a digit symbol is a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata <= 8'd9))
    else $error("digit out of range");

  // the sign carries no digit and never ends a run
  a_sign_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0 && !m_tlast))
    else $error("malformed sign symbol");

  // a sign is always followed by a digit
  a_sign_then_digit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser) |=> (m_tvalid && !m_tuser))
    else $error("no digit after sign");
`endif

endmodule

`default_nettype wire
